// File: hdl/lfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types and constants of the lidar frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam logic [7:0] START_RESET = 8'hAA;
  localparam logic [7:0] TYPE_SCAN   = 8'h61;
  localparam logic [7:0] CMD_DATA    = 8'hAD;
  localparam logic [7:0] CMD_ERRPKT  = 8'hAE;
  localparam logic [7:0] VER_DATA    = 8'h01;
  localparam logic [7:0] VER_ERRPKT  = 8'h00;

  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_START_BYTE = 3'd0;

  typedef enum logic [4:0] {
    PH_HUNT, PH_FL_HI, PH_FL_LO, PH_VER, PH_TYPE, PH_CMD, PH_DL_HI, PH_DL_LO,
    PH_SPEED, PH_CMD_X, PH_DL_HI_X, PH_DL_LO_X, PH_SPEED_X, PH_ZO_HI, PH_ZO_LO,
    PH_SA_HI, PH_SA_LO, PH_SIG, PH_D_HI, PH_D_LO, PH_CK_HI, PH_CK_LO
  } phase_t;

  typedef enum logic [2:0] {
    K_SAMPLE = 3'd0,
    K_OK     = 3'd1,
    K_BADSUM = 3'd2,
    K_HDRERR = 3'd3,
    K_ERRPKT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {BK_IDLE, BK_DIV, BK_DONE} back_state_t;

  // one classified result handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  count;
    logic [14:0] divisor;
    logic [12:0] sa10;
    logic [7:0]  sig;
    logic [15:0] distance;
    logic [7:0]  speed;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hdl/lfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_front
// Byte-level frame state machine; pushes one job per result-producing byte.
// ----------------------------------------------------------------------------
module lfp_front import lfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] frame_mark,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  q_status_t  q_stat,
  output logic       push,
  output job_t       job
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [7:0]  ver_r, ver_nxt, cmd_r, cmd_nxt, speed_r, speed_nxt;
  logic [7:0]  sa_hi_r, sa_hi_nxt;
  logic [12:0] sa10_r, sa10_nxt;
  logic [14:0] div_r, div_nxt;
  logic [7:0]  total_r, total_nxt, count_r, count_nxt;
  logic [7:0]  sig_r, sig_nxt, high_r, high_nxt;

  logic        acc;
  logic [7:0]  b;
  logic [15:0] dl_full, dlm5, sa_full;
  logic [31:0] div_prod, sa_prod;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign b        = in_rx_byte;

  // (dl - 5) / 3 and start_angle / 10 by reciprocal multiplication
  assign dl_full  = {dlen_r[15:8], b};
  assign dlm5     = dl_full - 16'd5;
  assign div_prod = 32'(dlm5) * 32'd43691;
  assign sa_full  = {sa_hi_r, b};
  assign sa_prod  = 32'(sa_full) * 32'd52429;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= '0;
      dlen_r  <= '0;
      ver_r   <= '0;
      cmd_r   <= '0;
      speed_r <= '0;
      sa_hi_r <= '0;
      sa10_r  <= '0;
      div_r   <= '0;
      total_r <= '0;
      count_r <= '0;
      sig_r   <= '0;
      high_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      dlen_r  <= dlen_nxt;
      ver_r   <= ver_nxt;
      cmd_r   <= cmd_nxt;
      speed_r <= speed_nxt;
      sa_hi_r <= sa_hi_nxt;
      sa10_r  <= sa10_nxt;
      div_r   <= div_nxt;
      total_r <= total_nxt;
      count_r <= count_nxt;
      sig_r   <= sig_nxt;
      high_r  <= high_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    dlen_nxt  = dlen_r;
    ver_nxt   = ver_r;
    cmd_nxt   = cmd_r;
    speed_nxt = speed_r;
    sa_hi_nxt = sa_hi_r;
    sa10_nxt  = sa10_r;
    div_nxt   = div_r;
    total_nxt = total_r;
    count_nxt = count_r;
    sig_nxt   = sig_r;
    high_nxt  = high_r;
    push      = 1'b0;
    job.kind     = K_SAMPLE;
    job.count    = count_r;
    job.divisor  = div_r;
    job.sa10     = sa10_r;
    job.sig      = sig_r;
    job.distance = {high_r, b};
    job.speed    = speed_r;
    if (acc) begin
      if (phase_r != PH_HUNT && phase_r != PH_CK_HI && phase_r != PH_CK_LO) begin
        sum_nxt = sum_r + 16'(b);
      end
      unique case (phase_r)
        PH_HUNT: begin
          if (b == frame_mark) begin
            sum_nxt   = 16'(b);
            phase_nxt = PH_FL_HI;
          end
        end
        PH_FL_HI: phase_nxt = PH_FL_LO;
        PH_FL_LO: phase_nxt = PH_VER;
        PH_VER: begin
          ver_nxt   = b;
          phase_nxt = PH_TYPE;
        end
        PH_TYPE:  phase_nxt = (b == TYPE_SCAN) ? PH_CMD : PH_CMD_X;
        PH_CMD, PH_CMD_X: begin
          cmd_nxt   = b;
          phase_nxt = (phase_r == PH_CMD) ? PH_DL_HI : PH_DL_HI_X;
        end
        PH_DL_HI, PH_DL_HI_X: begin
          dlen_nxt  = {b, 8'h00};
          phase_nxt = (phase_r == PH_DL_HI) ? PH_DL_LO : PH_DL_LO_X;
        end
        PH_DL_LO, PH_DL_LO_X: begin
          dlen_nxt  = dl_full;
          div_nxt   = (dl_full < 16'd5) ? 15'd0 : div_prod[31:17];
          phase_nxt = (phase_r == PH_DL_LO) ? PH_SPEED : PH_SPEED_X;
        end
        PH_SPEED_X: begin
          speed_nxt = b;
          job.speed = b;
          job.kind  = K_HDRERR;
          push      = 1'b1;
          phase_nxt = PH_HUNT;
        end
        PH_SPEED: begin
          speed_nxt = b;
          job.speed = b;
          if (ver_r == VER_DATA && cmd_r == CMD_DATA) begin
            phase_nxt = PH_ZO_HI;
          end else begin
            push      = 1'b1;
            phase_nxt = PH_HUNT;
            job.kind  = (ver_r == VER_ERRPKT && cmd_r == CMD_ERRPKT) ? K_ERRPKT : K_HDRERR;
          end
        end
        PH_ZO_HI: phase_nxt = PH_ZO_LO;
        PH_ZO_LO: phase_nxt = PH_SA_HI;
        PH_SA_HI: begin
          sa_hi_nxt = b;
          phase_nxt = PH_SA_LO;
        end
        PH_SA_LO: begin
          sa10_nxt  = sa_prod[31:19];
          total_nxt = div_r[7:0];
          count_nxt = '0;
          phase_nxt = (div_r[7:0] == 8'd0) ? PH_CK_HI : PH_SIG;
        end
        PH_SIG: begin
          sig_nxt   = b;
          phase_nxt = PH_D_HI;
        end
        PH_D_HI: begin
          high_nxt  = b;
          phase_nxt = PH_D_LO;
        end
        PH_D_LO: begin
          push      = 1'b1;
          count_nxt = count_r + 8'd1;
          phase_nxt = ((count_r + 8'd1) >= total_r) ? PH_CK_HI : PH_SIG;
        end
        PH_CK_HI: begin
          high_nxt  = b;
          phase_nxt = PH_CK_LO;
        end
        PH_CK_LO: begin
          push      = 1'b1;
          job.kind  = ({high_r, b} == sum_r) ? K_OK : K_BADSUM;
          phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

endmodule

// File: hdl/lfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_queue
// Four-entry job queue between front and back.
// ----------------------------------------------------------------------------
module lfp_queue import lfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      wr_job,
  input  logic      pop,
  output job_t      rd_job,
  output q_status_t stat
);

  job_t       mem_r [4];
  logic [2:0] wp_r, rp_r;

  assign stat.empty = (wp_r == rp_r);
  assign stat.full  = (wp_r[1:0] == rp_r[1:0]) && (wp_r[2] != rp_r[2]);
  assign rd_job     = mem_r[rp_r[1:0]];

  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      mem_r[wp_r[1:0]] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push && !stat.full) wp_r <= wp_r + 3'd1;
      if (pop && !stat.empty) rp_r <= rp_r + 3'd1;
    end
  end

endmodule

// File: hdl/lfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_back
// Angle slot by iterative division, then the output register.
// ----------------------------------------------------------------------------
module lfp_back import lfp_pkg::*; #(
  parameter int unsigned ANGLE_SPAN = 225
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_status_t   q_stat,
  input  job_t        q_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [10:0] out_angle_index,
  output logic [7:0]  out_signal,
  output logic [15:0] out_distance,
  output logic [7:0]  out_rotation_speed
);

  localparam int unsigned SPAN_W = $clog2(ANGLE_SPAN + 1);
  localparam int unsigned DVD_W  = 8 + SPAN_W;
  localparam int unsigned CNT_W  = $clog2(DVD_W + 1);

  back_state_t      st_r, st_nxt;
  job_t             job_r, job_nxt;
  logic [14:0]      rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [10:0]      ang_r, ang_nxt;
  logic [7:0]       sig_r, sig_nxt, spd_r, spd_nxt;
  logic [15:0]      dist_r, dist_nxt;

  logic [15:0]      shifted;
  logic [13:0]      ang_sum;
  logic [27:0]      ang_prod;

  assign shifted  = {rem_r, quo_r[DVD_W-1]};
  assign ang_sum  = 14'(job_r.sa10) + 14'(quo_r);
  assign ang_prod = 28'(ang_sum) * 28'd13108;

  assign out_valid          = ov_r;
  assign out_kind           = kind_r;
  assign out_angle_index    = ang_r;
  assign out_signal         = sig_r;
  assign out_distance       = dist_r;
  assign out_rotation_speed = spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    job_r  <= job_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    kind_r <= kind_nxt;
    ang_r  <= ang_nxt;
    sig_r  <= sig_nxt;
    dist_r <= dist_nxt;
    spd_r  <= spd_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    job_nxt  = job_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r && !out_ready;
    kind_nxt = kind_r;
    ang_nxt  = ang_r;
    sig_nxt  = sig_r;
    dist_nxt = dist_r;
    spd_nxt  = spd_r;
    pop      = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          job_nxt = q_job;
          rem_nxt = '0;
          quo_nxt = DVD_W'(32'(q_job.count) * 32'(ANGLE_SPAN));
          cnt_nxt = CNT_W'(DVD_W);
          if (q_job.kind == K_SAMPLE && q_job.divisor != 15'd0) begin
            st_nxt = BK_DIV;
          end else begin
            quo_nxt = '0;
            st_nxt  = BK_DONE;
          end
        end
      end
      BK_DIV: begin
        if (shifted >= {1'b0, job_r.divisor}) begin
          rem_nxt = 15'(shifted - {1'b0, job_r.divisor});
          quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[14:0];
          quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) st_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt   = 1'b1;
          kind_nxt = job_r.kind;
          spd_nxt  = job_r.speed;
          if (job_r.kind == K_SAMPLE) begin
            ang_nxt  = ang_prod[26:16];
            sig_nxt  = job_r.sig;
            dist_nxt = job_r.distance;
          end else begin
            ang_nxt  = '0;
            sig_nxt  = '0;
            dist_nxt = '0;
          end
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

endmodule

// File: hdl/lidar_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_frame_parser
// Byte-serial lidar frame parser: header checks, samples, checksum.
// ----------------------------------------------------------------------------
//  channel | ports            | transfer when
//  input   | in_*             | in_valid && in_ready, one rx byte
//  output  | out_*            | out_valid && out_ready, one result
//  config  | cfg_p*           | cfg_psel && cfg_penable && cfg_pwrite
//
// Cycles: the front takes one byte per cycle while the job queue has room.
// A sample result passes the job queue, the one-bit-per-cycle divider and the
// output register; other results skip the divider.
// Reset: synchronous, active low; parser returns to hunting, start byte 0xAA.
// Stalls: a held output only stalls the back; the front keeps taking bytes
// until the four-entry queue fills.
module lidar_frame_parser import lfp_pkg::*; #(
  parameter int unsigned ANGLE_SPAN = 225
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [10:0]       out_angle_index,
  output logic [7:0]        out_signal,
  output logic [15:0]       out_distance,
  output logic [7:0]        out_rotation_speed,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [7:0] start_r;
  q_status_t  q_stat;
  job_t       push_job, pop_job;
  logic       push, pop;

  // start byte register; reads decode only address 0, writes any address with bit 2 clear
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_START_BYTE) ? {24'd0, start_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_START_BYTE[2]) begin
      start_r <= cfg_pwdata[7:0];
    end
  end

  lfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_mark (start_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_stat     (q_stat),
    .push       (push),
    .job        (push_job)
  );

  lfp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (pop_job),
    .stat   (q_stat)
  );

  lfp_back #(.ANGLE_SPAN(ANGLE_SPAN)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .q_job              (pop_job),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_angle_index    (out_angle_index),
    .out_signal         (out_signal),
    .out_distance       (out_distance),
    .out_rotation_speed (out_rotation_speed)
  );

endmodule

// File: hdl/lfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_checker
// Port-level checks of the lidar frame parser.
// ----------------------------------------------------------------------------
module lfp_checker import lfp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [10:0] out_angle_index,
  input logic [7:0]  out_signal,
  input logic [15:0] out_distance,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_distance) && $stable(out_angle_index))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_non_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_SAMPLE |->
    out_angle_index == 11'd0 && out_signal == 8'd0 && out_distance == 16'd0)
    else $error("non-sample result carries sample data");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= K_ERRPKT)
    else $error("bad result kind");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port not ready");

endmodule

bind lidar_frame_parser lfp_checker u_lfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_angle_index (out_angle_index),
  .out_signal      (out_signal),
  .out_distance    (out_distance),
  .cfg_pready      (cfg_pready)
);

// File: tb/tb_lidar_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_frame_parser
// Self-checking bench for the byte-serial lidar frame parser.
// ----------------------------------------------------------------------------
// Bytes are pushed through the valid/ready input, results are pulled from the
// output with random stalls and compared field by field against an in-bench
// frame parser model. A directed table opens the run, then whole random
// frames (good, bad checksum, bad header, error packet, short data) mixed
// with line noise, under three start-byte settings.
module tb_lidar_frame_parser;
  import lfp_pkg::*;

  localparam int unsigned SPAN      = 225;
  localparam int unsigned STALL_MAX = 20000;
  localparam int unsigned N_ITEMS   = 1250;

  typedef struct packed {
    kind_t       kind;
    logic [10:0] angle;
    logic [7:0]  sig;
    logic [15:0] distance;
    logic [7:0]  speed;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_kind;
  logic [10:0] out_angle_index;
  logic [7:0] out_signal;
  logic [15:0] out_distance;
  logic [7:0] out_rotation_speed;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always #5 clk = ~clk;

  lidar_frame_parser #(.ANGLE_SPAN(SPAN)) i_dut (.*);

  // ---- frame parser model state ----
  logic [7:0]  m_start;
  phase_t      m_phase;
  logic [15:0] m_sum, m_dlen, m_sang;
  logic [7:0]  m_ver, m_cmd, m_speed, m_total, m_count, m_sig, m_high;
  logic [14:0] m_div;

  result_t expected_q[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_results = 0;
  int unsigned n_samples = 0;
  int unsigned idle_cycles = 0;
  bit quiet = 1'b0;         // no random idling while set
  bit hold_off = 1'b0;      // long receiver stall request

  task automatic report(input string what, input result_t got, input result_t exp);
    errors++;
    $display("mismatch %s: got k%0d a%0d s%0d d%0d r%0d exp k%0d a%0d s%0d d%0d r%0d",
             what, got.kind, got.angle, got.sig, got.distance, got.speed,
             exp.kind, exp.angle, exp.sig, exp.distance, exp.speed);
  endtask

  function automatic void parser_reset();
    m_start = START_RESET;
    m_phase = PH_HUNT;
    {m_sum, m_dlen, m_sang} = '0;
    {m_ver, m_cmd, m_speed, m_total, m_count, m_sig, m_high} = '0;
    m_div = '0;
  endfunction

  function automatic result_t mk(kind_t k, logic [10:0] a, logic [7:0] s, logic [15:0] d);
    result_t r;
    r.kind = k; r.angle = a; r.sig = s; r.distance = d; r.speed = m_speed;
    return r;
  endfunction

  // advance the model by one byte; returns 1 when a result is produced
  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    int unsigned q;
    logic [16:0] dl5;
    r = '0;
    if (!(m_phase inside {PH_HUNT, PH_CK_HI, PH_CK_LO})) m_sum += 16'(b);
    case (m_phase)
      PH_HUNT: if (b == m_start) begin
        m_sum = 16'(b); m_phase = PH_FL_HI;
      end
      PH_FL_HI: m_phase = PH_FL_LO;
      PH_FL_LO: m_phase = PH_VER;
      PH_VER: begin m_ver = b; m_phase = PH_TYPE; end
      PH_TYPE: m_phase = (b == TYPE_SCAN) ? PH_CMD : PH_CMD_X;
      PH_CMD: begin m_cmd = b; m_phase = PH_DL_HI; end
      PH_CMD_X: begin m_cmd = b; m_phase = PH_DL_HI_X; end
      PH_DL_HI: begin m_dlen = {b, 8'h00}; m_phase = PH_DL_LO; end
      PH_DL_HI_X: begin m_dlen = {b, 8'h00}; m_phase = PH_DL_LO_X; end
      PH_DL_LO: begin m_dlen[7:0] = b; m_phase = PH_SPEED; end
      PH_DL_LO_X: begin m_dlen[7:0] = b; m_phase = PH_SPEED_X; end
      PH_SPEED_X: begin
        m_speed = b; m_phase = PH_HUNT; r = mk(K_HDRERR, '0, '0, '0); return 1;
      end
      PH_SPEED: begin
        m_speed = b;
        if (m_ver == VER_DATA && m_cmd == CMD_DATA) begin
          m_phase = PH_ZO_HI;
          return 0;
        end
        m_phase = PH_HUNT;
        r = mk((m_ver == VER_ERRPKT && m_cmd == CMD_ERRPKT) ? K_ERRPKT : K_HDRERR,
               '0, '0, '0);
        return 1;
      end
      PH_ZO_HI: m_phase = PH_ZO_LO;
      PH_ZO_LO: m_phase = PH_SA_HI;
      PH_SA_HI: begin m_sang = {b, 8'h00}; m_phase = PH_SA_LO; end
      PH_SA_LO: begin
        m_sang[7:0] = b;
        if (m_dlen < 5) m_div = '0;
        else begin
          dl5 = 17'(m_dlen) - 17'd5;
          m_div = 15'(dl5 / 3);
        end
        m_total = m_div[7:0];
        m_count = '0;
        m_phase = (m_total == 0) ? PH_CK_HI : PH_SIG;
      end
      PH_SIG: begin m_sig = b; m_phase = PH_D_HI; end
      PH_D_HI: begin m_high = b; m_phase = PH_D_LO; end
      PH_D_LO: begin
        q = (m_div != 0) ? (m_count * SPAN) / m_div : 0;
        r = mk(K_SAMPLE, 11'((m_sang / 10 + q) / 5), m_sig, {m_high, b});
        m_count++;
        m_phase = (m_count >= m_total) ? PH_CK_HI : PH_SIG;
        return 1;
      end
      PH_CK_HI: begin m_high = b; m_phase = PH_CK_LO; end
      PH_CK_LO: begin
        m_phase = PH_HUNT;
        r = mk(({m_high, b} == m_sum) ? K_OK : K_BADSUM, '0, '0, '0);
        return 1;
      end
      default: m_phase = PH_HUNT;
    endcase
    return 0;
  endfunction

  // ---- input driver; valid stays up between back-to-back bytes ----
  task automatic send_byte(input logic [7:0] b);
    result_t r;
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer happened at this edge
    if (parse_byte(b, r)) expected_q.push_back(r);
    n_sent++;
  endtask

  // ---- directed table: byte, expect-flag, typed expectation ----
  typedef struct {
    logic [7:0] b;
    bit         chk;
    result_t    exp;
  } row_t;

  row_t dir_tab[$];
  function automatic void add_row(logic [7:0] b, bit chk = 0, result_t e = '0);
    row_t rw;
    rw.b = b; rw.chk = chk; rw.exp = e;
    dir_tab.push_back(rw);
  endfunction

  // random frame builder; shape picks well-formed vs. broken variants
  task automatic send_frame();
    logic [7:0] fr[$];
    logic [15:0] sum, dl, sa;
    int unsigned shape, ns;
    shape = $urandom_range(99);
    ns = $urandom_range(0, 6);
    dl = (shape < 5) ? 16'($urandom_range(0, 4)) : 16'(5 + 3 * ns + $urandom_range(0, 2));
    if (shape >= 95) dl = 16'($urandom);   // huge length, truncated count
    if (dl > 16'd800 && shape >= 95) dl = {8'h00, dl[7:0]} + 16'd770; // count wraps near 256
    sa = (shape % 7 == 0) ? 16'hFFFF : 16'($urandom_range(0, 3599));
    fr.push_back(m_start);
    fr.push_back(8'($urandom)); fr.push_back(8'($urandom));
    if (shape < 80) begin
      fr.push_back(VER_DATA); fr.push_back(TYPE_SCAN); fr.push_back(CMD_DATA);
    end else if (shape < 86) begin
      fr.push_back(VER_ERRPKT); fr.push_back(TYPE_SCAN); fr.push_back(CMD_ERRPKT);
    end else if (shape < 92) begin
      fr.push_back(8'($urandom)); fr.push_back(8'($urandom)); fr.push_back(8'($urandom));
    end else begin
      fr.push_back(VER_DATA); fr.push_back(TYPE_SCAN); fr.push_back(8'($urandom));
    end
    fr.push_back(dl[15:8]); fr.push_back(dl[7:0]); fr.push_back(8'($urandom));
    fr.push_back(8'($urandom)); fr.push_back(8'($urandom));
    fr.push_back(sa[15:8]); fr.push_back(sa[7:0]);
    ns = (dl < 5) ? 0 : ((dl - 5) / 3) % 256;
    repeat (3 * ns) fr.push_back(8'($urandom));
    sum = '0;
    foreach (fr[i]) sum += 16'(fr[i]);
    if ($urandom_range(9) == 0) sum ^= 16'(1 << $urandom_range(15));
    fr.push_back(sum[15:8]); fr.push_back(sum[7:0]);
    foreach (fr[i]) send_byte(fr[i]);
    // noise between frames
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] v);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= REG_START_BYTE; cfg_pwdata <= {24'h0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    m_start = v;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // ---- output monitor and receiver stalls ----
  always @(posedge clk) begin
    result_t got, exp;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.kind = kind_t'(out_kind); got.angle = out_angle_index; got.sig = out_signal;
        got.distance = out_distance; got.speed = out_rotation_speed;
        n_results++;
        if (got.kind == K_SAMPLE) n_samples++;
        if (expected_q.size() == 0) report("unexpected", got, '0);
        else begin
          exp = expected_q.pop_front();
          if (got.kind != exp.kind) report("kind", got, exp);
          else if (got.angle != exp.angle) report("angle_index", got, exp);
          else if (got.sig != exp.sig) report("signal", got, exp);
          else if (got.distance != exp.distance) report("distance", got, exp);
          else if (got.speed != exp.speed) report("rotation_speed", got, exp);
        end
      end
      out_ready <= !hold_off && (quiet || $urandom_range(99) >= 8);
    end
  end

  // long receiver hold-off, counted here so the sender keeps pushing
  initial begin
    wait (n_sent >= 100);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    result_t e;
    parser_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // noise, error packet with speed 0xFF, then a frame whose header bytes
    // are all ones (bad type) ending with speed 0x00
    add_row(8'h00); add_row(8'hAA); add_row(8'h00); add_row(8'h0A);
    add_row(VER_ERRPKT); add_row(TYPE_SCAN); add_row(CMD_ERRPKT);
    add_row(8'h00); add_row(8'h00);
    e = '{K_ERRPKT, 11'd0, 8'd0, 16'd0, 8'hFF}; add_row(8'hFF, 1, e);
    add_row(8'hAA); add_row(8'hFF); add_row(8'hFF); add_row(8'hFF); add_row(8'hFF);
    add_row(8'hFF); add_row(8'hFF); add_row(8'hFF);
    e = '{K_HDRERR, 11'd0, 8'd0, 16'd0, 8'h00}; add_row(8'h00, 1, e);
    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b);
      if (dir_tab[i].chk) begin
        if (expected_q.size() == 0) report("table", '0, dir_tab[i].exp);
        else if (expected_q[$] != dir_tab[i].exp)
          report("table", expected_q[$], dir_tab[i].exp);
      end
    end
    wait_drained();

    // random frames over three start-byte settings including both extremes
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) cfg_write(8'h00);
      if (ph == 2) cfg_write(8'hFF);
      quiet = (ph == 1);
      while (n_sent < (ph + 1) * N_ITEMS / 3) begin
        if ($urandom_range(9) == 0) send_byte(8'($urandom));
        else send_frame();
      end
      wait_drained();    // sender pauses until every result is in
    end
    cfg_write(START_RESET);

    $display("run: %0d bytes sent, %0d results checked (%0d samples), 3 start bytes",
             n_sent, n_results, n_samples);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
hdl/lfp_pkg.sv
hdl/lfp_front.sv
hdl/lfp_queue.sv
hdl/lfp_back.sv
hdl/lidar_frame_parser.sv
hdl/lfp_checker.sv
tb/tb_lidar_frame_parser.sv
